### src/assert_macros.svh
// Assertion macros used by the checker module.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is asserted (active low).
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### src/spq_pkg.sv
// Types and constants for the sorted priority queue.
// No dependencies; used by every module of the block.
package spq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int FILL_W      = 5;
    localparam int DATA_W      = 32;

    typedef enum logic {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic signed [DATA_W-1:0] prio;
    } entry_t;

    // Operation applied to every slot of the chain in the same cycle.
    typedef struct packed {
        logic enq;
        logic deq;
    } ctrl_t;

endpackage

### src/spq_cell.sv
// One slot of the sorted chain: holds an entry and moves it along the chain.
// Depends on spq_pkg.
module spq_cell import spq_pkg::*; (
    input  logic   aclk,
    input  ctrl_t  ctrl,
    input  logic   occupied,
    input  logic   prev_ge,
    input  entry_t new_entry,
    input  entry_t left_entry,
    input  entry_t right_entry,
    output entry_t entry,
    output logic   ge
);

    entry_t entry_reg;
    entry_t entry_next;

    // New entry belongs at or ahead of this slot.
    assign ge = !occupied || !($signed(entry_reg.prio) < $signed(new_entry.prio));

    always_comb begin
        entry_next = entry_reg;
        priority if (ctrl.enq) begin
            if (ge && prev_ge) begin
                entry_next = left_entry;
            end else if (ge) begin
                entry_next = new_entry;
            end
        end else if (ctrl.deq) begin
            entry_next = right_entry;
        end else begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

### src/sorted_priority_queue.sv
// Sorted priority queue, smallest priority first, built as a chain of slot cells.
// Depends on spq_pkg and spq_cell.
//
// Input channel (s_*): s_op selects enqueue or dequeue of the head; an enqueue
// carries s_item_data and s_item_priority. Every input transfer gives exactly one
// result transfer on the m_* channel: status, the removed head on a dequeue,
// and the fill level after the operation.
// All slots compare against the new priority in parallel and shift by one in
// the same cycle, so the result is registered and m_valid rises in the cycle
// after the input transfer; throughput is one item per cycle while m_ready is high.
// The result sits in an output register; s_ready is high while that register
// is empty or being taken, so a stalled receiver holds back at most one
// result and then stops input transfers until m_ready returns.
// Among equal priorities the newest entry is served first. An enqueue on a full
// queue is refused with status full; a dequeue on an empty queue returns
// status empty with zero data.
// Reset (aresetn low, synchronous) empties the queue and drops any pending
// result; no clearing pass is needed, slot contents are only read below the count.
module sorted_priority_queue import spq_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_op,
    input  logic signed [DATA_W-1:0] s_item_data,
    input  logic signed [DATA_W-1:0] s_item_priority,
    output logic                     m_valid,
    input  logic                     m_ready,
    output status_t                  m_status,
    output logic signed [DATA_W-1:0] m_out_data,
    output logic signed [DATA_W-1:0] m_out_priority,
    output logic                     m_out_valid,
    output logic [FILL_W-1:0]        m_fill_level
);

    logic [COUNT_W-1:0]       count_reg, count_next;
    logic                     m_valid_reg, m_valid_next;
    status_t                  status_reg, status_next;
    logic signed [DATA_W-1:0] odata_reg, odata_next;
    logic signed [DATA_W-1:0] oprio_reg, oprio_next;
    logic                     ovalid_reg, ovalid_next;
    logic [FILL_W-1:0]        fill_reg, fill_next;

    ctrl_t                    ctrl;
    entry_t                   new_entry;
    entry_t                   cell_entry [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]   cell_ge;
    logic [QUEUE_DEPTH-1:0]   cell_occ;
    logic                     accept;
    logic                     full;
    logic                     empty;

    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign full      = (count_reg == COUNT_W'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign new_entry = '{data: s_item_data, prio: s_item_priority};

    genvar i;
    generate
        for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
            entry_t left_e;
            entry_t right_e;
            logic   prev_g;

            assign cell_occ[i] = (count_reg > COUNT_W'(i));

            if (i == 0) begin : g_head
                assign left_e = '0;
                assign prev_g = 1'b0;
            end else begin : g_body
                assign left_e = cell_entry[i-1];
                assign prev_g = cell_ge[i-1];
            end

            if (i == QUEUE_DEPTH - 1) begin : g_tail
                assign right_e = '0;
            end else begin : g_mid
                assign right_e = cell_entry[i+1];
            end

            spq_cell u_cell (
                .aclk       (aclk),
                .ctrl       (ctrl),
                .occupied   (cell_occ[i]),
                .prev_ge    (prev_g),
                .new_entry  (new_entry),
                .left_entry (left_e),
                .right_entry(right_e),
                .entry      (cell_entry[i]),
                .ge         (cell_ge[i])
            );
        end
    endgenerate

    always_comb begin
        ctrl.enq     = accept && (s_op == OP_ENQ) && !full;
        ctrl.deq     = accept && (s_op == OP_DEQ) && !empty;
        count_next   = count_reg;
        status_next  = status_reg;
        odata_next   = odata_reg;
        oprio_next   = oprio_reg;
        ovalid_next  = ovalid_reg;
        fill_next    = fill_reg;
        m_valid_next = m_valid_reg && !m_ready;

        if (ctrl.enq) begin
            count_next = count_reg + COUNT_W'(1);
        end else if (ctrl.deq) begin
            count_next = count_reg - COUNT_W'(1);
        end

        if (accept) begin
            m_valid_next = 1'b1;
            odata_next   = '0;
            oprio_next   = '0;
            ovalid_next  = 1'b0;
            fill_next    = FILL_W'(count_next);
            unique case (s_op)
                OP_ENQ: begin
                    status_next = full ? ST_FULL : ST_OK;
                end
                OP_DEQ: begin
                    status_next = empty ? ST_EMPTY : ST_OK;
                    if (!empty) begin
                        odata_next  = cell_entry[0].data;
                        oprio_next  = cell_entry[0].prio;
                        ovalid_next = 1'b1;
                    end
                end
                default: begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        odata_reg  <= odata_next;
        oprio_reg  <= oprio_next;
        ovalid_reg <= ovalid_next;
        fill_reg   <= fill_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = status_reg;
    assign m_out_data     = odata_reg;
    assign m_out_priority = oprio_reg;
    assign m_out_valid    = ovalid_reg;
    assign m_fill_level   = fill_reg;

endmodule

### src/spq_checker.sv
// Port-level checks for the sorted priority queue, bound to the top level.
// Depends on spq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module spq_assertions import spq_pkg::*; (
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     m_valid,
    input logic                     m_ready,
    input status_t                  m_status,
    input logic signed [DATA_W-1:0] m_out_data,
    input logic signed [DATA_W-1:0] m_out_priority,
    input logic                     m_out_valid,
    input logic [FILL_W-1:0]        m_fill_level
);

    logic                          stalled;
    logic [2+2*DATA_W+1+FILL_W-1:0] res_bus;

    assign stalled = m_valid && !m_ready;
    assign res_bus = {m_status, m_out_data, m_out_priority, m_out_valid, m_fill_level};

    `ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> !m_valid, "result pending after reset")

    `ASSERT_CLK(a_stall_hold, aclk, aresetn,
        stalled |=> m_valid && $stable(res_bus), "stalled result changed")

    `ASSERT_CLK(a_head_ok, aclk, aresetn,
        m_valid && m_out_valid |-> m_status == ST_OK, "removed entry without ok status")

    `ASSERT_CLK(a_empty_level, aclk, aresetn,
        m_valid && m_status == ST_EMPTY |-> m_fill_level == '0 && !m_out_valid,
        "empty status with entries held")

    `ASSERT_CLK(a_full_level, aclk, aresetn,
        m_valid && m_status == ST_FULL |-> m_fill_level == FILL_W'(QUEUE_DEPTH),
        "full status below depth")

endmodule

bind sorted_priority_queue spq_assertions u_spq_assertions (.*);
